// ===== hw/rtl/irom_pkg.sv =====
`timescale 1ns / 1ps

package irom_pkg;

  localparam int ValueW = 12;
  localparam int InDataW = 16;
  localparam int SymW = 8;
  localparam int StepW = 4;

  localparam logic [ValueW-1:0] ValueMax = 12'd3999;

  // ASCII letters
  localparam logic [SymW-1:0] ChM = 8'h4D;
  localparam logic [SymW-1:0] ChD = 8'h44;
  localparam logic [SymW-1:0] ChC = 8'h43;
  localparam logic [SymW-1:0] ChL = 8'h4C;
  localparam logic [SymW-1:0] ChX = 8'h58;
  localparam logic [SymW-1:0] ChV = 8'h56;
  localparam logic [SymW-1:0] ChI = 8'h49;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PAIR,
    ST_ERR
  } state_e;

  typedef struct packed {
    logic              ge;
    logic [ValueW-1:0] diff;
  } sub_res_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            range_error;
  } out_word_t;

  // Greedy step table, largest weight first:
  // M CM D CD C XC L XL X IX V IV I
  function automatic logic [ValueW-1:0] step_weight(input logic [StepW-1:0] k);
    logic [ValueW-1:0] w;
    unique case (k)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  function automatic logic [SymW-1:0] step_first(input logic [StepW-1:0] k);
    logic [SymW-1:0] c;
    unique case (k)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      default: c = ChI;
    endcase
    return c;
  endfunction

  // subtractive steps emit a second letter
  function automatic logic step_pair(input logic [StepW-1:0] k);
    return (k == 4'd1) || (k == 4'd3) || (k == 4'd5) ||
           (k == 4'd7) || (k == 4'd9) || (k == 4'd11);
  endfunction

  function automatic logic [SymW-1:0] step_second(input logic [StepW-1:0] k);
    logic [SymW-1:0] c;
    unique case (k)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      default: c = ChV;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/irom_sub.sv =====
`timescale 1ns / 1ps

module irom_sub (
  input  logic [irom_pkg::ValueW-1:0] rem_i,
  input  logic [irom_pkg::StepW-1:0]  step_i,
  output irom_pkg::sub_res_t          res_o
);
  import irom_pkg::*;

  logic [ValueW-1:0] weight;

  assign weight      = step_weight(step_i);
  assign res_o.ge    = (rem_i >= weight);
  assign res_o.diff  = rem_i - weight;

endmodule

// ===== hw/rtl/irom_outreg.sv =====
`timescale 1ns / 1ps

module irom_outreg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  irom_pkg::out_word_t       word_i,
  output logic                      free_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [irom_pkg::SymW-1:0] m_axis_tdata,
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser
);
  import irom_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q;

  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = word_q.symbol;
  assign m_axis_tlast  = word_q.last;
  assign m_axis_tuser  = word_q.range_error;

endmodule

// ===== hw/rtl/integer_to_roman_encoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)          tlast             tuser
// s_axis    in   value[11:0], zeros to 16    -                 -
// m_axis    out  symbol[7:0] (ASCII)         last char of run  range_error
//
// One compare/subtract unit walks a 13-step greedy table (M CM D CD C XC L XL
// X IX V IV I), one step per cycle: a match emits a letter, a miss advances.
// After accept, the walk emits each character or skips a table step in turn; an
// out-of-range value (0 or above 3999) instead loads a single error word.
// Input is not ready until the last word is loaded into the output register.
// A stalled output holds the walk at its next letter; misses still advance.
// Reset clears the sequencer and output valid.

module integer_to_roman_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [irom_pkg::InDataW-1:0] s_axis_tdata,   // value[11:0], pad[15:12]
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // symbol[7:0]
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser    // range_error
);
  import irom_pkg::*;

  state_e            state_q, state_d;
  logic [ValueW-1:0] rem_q, rem_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [SymW-1:0]   second_q, second_d;
  logic [ValueW-1:0] value;
  sub_res_t          sub_res;
  out_word_t         word;
  logic              load, out_free;

  assign value = s_axis_tdata[ValueW-1:0];

  irom_sub u_sub (
    .rem_i  (rem_q),
    .step_i (step_q),
    .res_o  (sub_res)
  );

  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    step_d        = step_q;
    second_d      = second_q;
    load          = 1'b0;
    word          = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          rem_d  = value;
          step_d = '0;
          if (value == '0 || value > ValueMax) begin
            state_d = ST_ERR;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load              = 1'b1;
          word.symbol       = '0;
          word.last         = 1'b1;
          word.range_error  = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (!sub_res.ge) begin
          step_d = step_q + 4'd1;
        end else if (out_free) begin
          load        = 1'b1;
          word.symbol = step_first(step_q);
          word.last   = !step_pair(step_q) && (sub_res.diff == '0);
          rem_d       = sub_res.diff;
          if (step_pair(step_q)) begin
            second_d = step_second(step_q);
            state_d  = ST_PAIR;
          end else if (sub_res.diff == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_PAIR: begin
        if (out_free) begin
          load        = 1'b1;
          word.symbol = second_q;
          word.last   = (rem_q == '0);
          state_d     = (rem_q == '0) ? ST_IDLE : ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    step_q   <= step_d;
    second_q <= second_d;
  end

  irom_outreg u_outreg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .word_i        (word),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hw/rtl/irom_checker.sv =====
`timescale 1ns / 1ps

module irom_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);
  import irom_pkg::*;

  // error word is a run of one, with a zero symbol
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error word not a single zero word");

  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata == ChM) || (m_axis_tdata == ChD) || (m_axis_tdata == ChC) ||
      (m_axis_tdata == ChL) || (m_axis_tdata == ChX) || (m_axis_tdata == ChV) ||
      (m_axis_tdata == ChI))
    else $error("symbol is not a numeral letter");

  // busy while a number is being converted
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled output word changed");

endmodule

bind integer_to_roman_encoder irom_checker u_irom_checker (.*);
